@@ hdl/spm_pkg.sv @@
// ----------------------------------------------------------------------------
// Sparse polynomial multiplier package
// Shared sizes, request codes and the command and status structures that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package spm_pkg;

  localparam int MAX_TERMS = 32;
  localparam int MAX_EXP   = 31;

  localparam int NUM_SUMS = 2 * MAX_EXP + 1;
  localparam int TW       = $clog2(MAX_TERMS);
  localparam int CW       = $clog2(MAX_TERMS + 1);
  localparam int SW       = $clog2(NUM_SUMS);

  localparam int REQ_W    = 2;
  localparam int COEFF_W  = 16;
  localparam int EXP_W    = 5;
  localparam int PCOEFF_W = 42;
  localparam int PEXP_W   = 6;

  localparam logic [REQ_W-1:0] REQ_FIRST  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SECOND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FINISH = 2'd2;

  typedef struct packed {
    logic load_first;
    logic load_second;
    logic pair_start;
    logic prod_cap;
    logic acc_step;
    logic emit_start;
    logic emit_sel;
    logic s_dec;
    logic out_load;
    logic clear;
  } spm_cmd_t;

  typedef struct packed {
    logic empty;
    logic pair_last;
    logic none;
    logic mark_s;
    logic lower_any;
    logic out_free;
  } spm_status_t;

endpackage

@@ hdl/spm_intf.sv @@
// ----------------------------------------------------------------------------
// Sparse polynomial multiplier channels
// Request and result channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface spm_req_if import spm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [REQ_W-1:0]          req_type;
  logic signed [COEFF_W-1:0] term_coeff;
  logic [EXP_W-1:0]          term_exp;

  modport source (output valid, req_type, term_coeff, term_exp, input ready);
  modport sink (input valid, req_type, term_coeff, term_exp, output ready);
endinterface

interface spm_rsp_if import spm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [PCOEFF_W-1:0] prod_coeff;
  logic [PEXP_W-1:0]          prod_exp;
  logic                       is_last;
  logic                       none;
  logic                       dropped;

  modport source (output valid, prod_coeff, prod_exp, is_last, none, dropped,
                  input ready);
  modport sink (input valid, prod_coeff, prod_exp, is_last, none, dropped,
                output ready);
endinterface

@@ hdl/sparse_polynomial_multiplier.sv @@
// ----------------------------------------------------------------------------
// Sparse polynomial multiplier
// Loads two sparse polynomials term by term and streams their product.
// ----------------------------------------------------------------------------
// Requests arrive on req_i. A term request of either polynomial writes the
// next free slot of that polynomial's term memory; a term beyond the
// capacity or with too large an exponent is dropped and flagged on the
// job's results. A finish request starts the product.
// Each term pair goes through term read, multiply and accumulate on the
// single multiplier and accumulator port; a finish then gives up to 63
// results in descending exponent order on rsp_o, the last one flagged.
// An empty product gives one result with the none flag.
// No request is taken while a finish is being worked on; the last result
// sits in the output register while new terms are already being loaded.
// If the receiver stalls, the walk waits on the output register.
// Reset clears the counts, presence marks and drop flag at once; the
// accumulators need no clearing since an unmarked slot reads as zero.
// ----------------------------------------------------------------------------
module sparse_polynomial_multiplier import spm_pkg::*; (
  input logic   clk_i,
  input logic   rst_ni,
  spm_req_if.sink   req_i,
  spm_rsp_if.source rsp_o
);

  spm_cmd_t    cmd;
  spm_status_t status;

  spm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .status_i    (status),
    .req_ready_o (req_i.ready),
    .cmd_o       (cmd)
  );

  spm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .term_coeff_i (req_i.term_coeff),
    .term_exp_i   (req_i.term_exp),
    .rsp_ready_i  (rsp_o.ready),
    .status_o     (status),
    .rsp_valid_o  (rsp_o.valid),
    .prod_coeff_o (rsp_o.prod_coeff),
    .prod_exp_o   (rsp_o.prod_exp),
    .is_last_o    (rsp_o.is_last),
    .none_o       (rsp_o.none),
    .dropped_o    (rsp_o.dropped)
  );

endmodule

@@ hdl/spm_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sparse polynomial multiplier controller
// Sequences term loads, the pairwise multiply and accumulate, and the
// descending walk over the exponent slots.
// ----------------------------------------------------------------------------
module spm_ctrl import spm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic [REQ_W-1:0] req_type_i,
  input  spm_status_t      status_i,
  output logic             req_ready_o,
  output spm_cmd_t         cmd_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_MUL_RD   = 3'd1;
  localparam logic [2:0] ST_MUL_PROD = 3'd2;
  localparam logic [2:0] ST_MUL_ACC  = 3'd3;
  localparam logic [2:0] ST_EMIT_RD  = 3'd4;
  localparam logic [2:0] ST_EMIT_WR  = 3'd5;

  logic [2:0] state_d, state_q;

  assign req_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          unique case (req_type_i)
            REQ_FIRST:  cmd_o.load_first  = 1'b1;
            REQ_SECOND: cmd_o.load_second = 1'b1;
            REQ_FINISH: begin
              if (status_i.empty) begin
                cmd_o.emit_start = 1'b1;
                state_d          = ST_EMIT_RD;
              end else begin
                cmd_o.pair_start = 1'b1;
                state_d          = ST_MUL_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MUL_RD: state_d = ST_MUL_PROD;
      ST_MUL_PROD: begin
        cmd_o.prod_cap = 1'b1;
        state_d        = ST_MUL_ACC;
      end
      ST_MUL_ACC: begin
        cmd_o.acc_step = 1'b1;
        if (status_i.pair_last) begin
          cmd_o.emit_start = 1'b1;
          state_d          = ST_EMIT_RD;
        end else begin
          state_d = ST_MUL_RD;
        end
      end
      ST_EMIT_RD: begin
        cmd_o.emit_sel = 1'b1;
        if (status_i.none || status_i.mark_s) begin
          state_d = ST_EMIT_WR;
        end else begin
          cmd_o.s_dec = 1'b1;
        end
      end
      ST_EMIT_WR: begin
        cmd_o.emit_sel = 1'b1;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (status_i.none || !status_i.lower_any) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            cmd_o.s_dec = 1'b1;
            state_d     = ST_EMIT_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/spm_dp.sv @@
// ----------------------------------------------------------------------------
// Sparse polynomial multiplier datapath
// Term memories, the multiplier, the accumulator memory with its presence
// marks, the loop counters and the result register.
// ----------------------------------------------------------------------------
module spm_dp import spm_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  spm_cmd_t                   cmd_i,
  input  logic signed [COEFF_W-1:0]  term_coeff_i,
  input  logic [EXP_W-1:0]           term_exp_i,
  input  logic                       rsp_ready_i,
  output spm_status_t                status_o,
  output logic                       rsp_valid_o,
  output logic signed [PCOEFF_W-1:0] prod_coeff_o,
  output logic [PEXP_W-1:0]          prod_exp_o,
  output logic                       is_last_o,
  output logic                       none_o,
  output logic                       dropped_o
);

  logic signed [COEFF_W-1:0] first_coeffs [MAX_TERMS];
  logic [EXP_W-1:0]          first_exps [MAX_TERMS];
  logic signed [COEFF_W-1:0] second_coeffs [MAX_TERMS];
  logic [EXP_W-1:0]          second_exps [MAX_TERMS];
  logic [PCOEFF_W-1:0]       sum_mem [NUM_SUMS];

  logic [CW-1:0]             first_cnt_q, second_cnt_q;
  logic                      overflow_q;
  logic [NUM_SUMS-1:0]       marks_q;
  logic [TW-1:0]             i_q, j_q;
  logic [SW-1:0]             s_q;

  logic signed [COEFF_W-1:0] a_coeff_q, b_coeff_q;
  logic [EXP_W-1:0]          a_exp_q, b_exp_q;
  logic [PCOEFF_W-1:0]       sum_rd_q;
  logic [PCOEFF_W-1:0]       prod_q;
  logic [SW-1:0]             k_q;

  logic                      exp_bad;
  logic                      i_last, j_last;
  logic [SW-1:0]             k_comb;
  logic [SW-1:0]             sum_raddr;
  logic signed [2*COEFF_W-1:0] prod_comb;
  logic [PCOEFF_W-1:0]       acc_base;
  logic [NUM_SUMS-1:0]       lower_mask;

  logic                      out_valid_q;
  logic [PCOEFF_W-1:0]       out_coeff_q;
  logic [PEXP_W-1:0]         out_exp_q;
  logic                      out_last_q, out_none_q, out_drop_q;

  assign exp_bad    = int'(term_exp_i) > MAX_EXP;
  assign i_last     = (CW'(i_q) + CW'(1)) == first_cnt_q;
  assign j_last     = (CW'(j_q) + CW'(1)) == second_cnt_q;
  assign k_comb     = SW'(PEXP_W'(a_exp_q) + PEXP_W'(b_exp_q));
  assign sum_raddr  = cmd_i.emit_sel ? s_q : k_comb;
  assign prod_comb  = a_coeff_q * b_coeff_q;
  assign acc_base   = marks_q[k_q] ? sum_rd_q : '0;
  assign lower_mask = (NUM_SUMS'(1) << s_q) - NUM_SUMS'(1);

  assign status_o.empty     = (first_cnt_q == '0) || (second_cnt_q == '0);
  assign status_o.pair_last = i_last && j_last;
  assign status_o.none      = (marks_q == '0);
  assign status_o.mark_s    = marks_q[s_q];
  assign status_o.lower_any = (marks_q & lower_mask) != '0;
  assign status_o.out_free  = !out_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_first && !exp_bad && (int'(first_cnt_q) < MAX_TERMS)) begin
      first_coeffs[first_cnt_q[TW-1:0]] <= term_coeff_i;
      first_exps[first_cnt_q[TW-1:0]]   <= term_exp_i;
    end
    if (cmd_i.load_second && !exp_bad && (int'(second_cnt_q) < MAX_TERMS)) begin
      second_coeffs[second_cnt_q[TW-1:0]] <= term_coeff_i;
      second_exps[second_cnt_q[TW-1:0]]   <= term_exp_i;
    end
    a_coeff_q <= first_coeffs[i_q];
    a_exp_q   <= first_exps[i_q];
    b_coeff_q <= second_coeffs[j_q];
    b_exp_q   <= second_exps[j_q];
    sum_rd_q  <= sum_mem[sum_raddr];
    if (cmd_i.prod_cap) begin
      prod_q <= PCOEFF_W'(prod_comb);
      k_q    <= k_comb;
    end
    if (cmd_i.acc_step) begin
      sum_mem[k_q] <= acc_base + prod_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
      overflow_q   <= 1'b0;
      marks_q      <= '0;
      i_q          <= '0;
      j_q          <= '0;
      s_q          <= '0;
    end else begin
      if (cmd_i.load_first) begin
        if (exp_bad || (int'(first_cnt_q) >= MAX_TERMS)) begin
          overflow_q <= 1'b1;
        end else begin
          first_cnt_q <= first_cnt_q + CW'(1);
        end
      end
      if (cmd_i.load_second) begin
        if (exp_bad || (int'(second_cnt_q) >= MAX_TERMS)) begin
          overflow_q <= 1'b1;
        end else begin
          second_cnt_q <= second_cnt_q + CW'(1);
        end
      end
      if (cmd_i.pair_start) begin
        i_q <= '0;
        j_q <= '0;
      end
      if (cmd_i.acc_step) begin
        marks_q[k_q] <= 1'b1;
        if (j_last) begin
          j_q <= '0;
          i_q <= i_q + TW'(1);
        end else begin
          j_q <= j_q + TW'(1);
        end
      end
      if (cmd_i.emit_start) begin
        s_q <= SW'(NUM_SUMS - 1);
      end else if (cmd_i.s_dec) begin
        s_q <= s_q - SW'(1);
      end
      if (cmd_i.clear) begin
        first_cnt_q  <= '0;
        second_cnt_q <= '0;
        overflow_q   <= 1'b0;
        marks_q      <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_coeff_q <= status_o.none ? '0 : sum_rd_q;
      out_exp_q   <= status_o.none ? '0 : PEXP_W'(s_q);
      out_last_q  <= status_o.none || !status_o.lower_any;
      out_none_q  <= status_o.none;
      out_drop_q  <= overflow_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rsp_valid_o  = out_valid_q;
  assign prod_coeff_o = out_coeff_q;
  assign prod_exp_o   = out_exp_q;
  assign is_last_o    = out_last_q;
  assign none_o       = out_none_q;
  assign dropped_o    = out_drop_q;

endmodule

@@ hdl/spm_checker.sv @@
// ----------------------------------------------------------------------------
// Sparse polynomial multiplier checker
// Port-level checks bound to the top level.
// ----------------------------------------------------------------------------
module spm_checker import spm_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic [REQ_W-1:0]           req_type_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic signed [PCOEFF_W-1:0] prod_coeff_i,
  input logic [PEXP_W-1:0]          prod_exp_i,
  input logic                       is_last_i,
  input logic                       none_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("Result valid dropped while stalled.");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(prod_coeff_i) && $stable(prod_exp_i))
    else $error("Result payload changed while stalled.");

  a_none_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && none_i |-> is_last_i && prod_coeff_i == '0 && prod_exp_i == '0)
    else $error("Empty product result carries data.");

  a_busy_mid_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !is_last_i |-> !req_ready_i)
    else $error("Request taken before the job's results were all produced.");

  a_finish_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && req_type_i == REQ_FINISH |=> !req_ready_i)
    else $error("Request taken right after a finish request.");

endmodule

bind sparse_polynomial_multiplier spm_checker u_spm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_type_i   (req_i.req_type),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .prod_coeff_i (rsp_o.prod_coeff),
  .prod_exp_i   (rsp_o.prod_exp),
  .is_last_i    (rsp_o.is_last),
  .none_i       (rsp_o.none)
);
